// ===== hdl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file of the serial line to frame parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on each rising edge, disabled while reset is held.
`define SLC_ASSERT_RST(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
        else $error(msg);

// Check a property on each rising edge, including during reset.
`define SLC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/slcan_pkg.sv =====
// Types, character codes and the hex digit decode shared by the line parser modules.
`default_nettype none

package slcan_pkg;

    // Line lengths and store addresses travel at a width that covers the largest line store.
    localparam int LEN_W = 7;
    typedef logic [LEN_W-1:0] len_t;

    // Received characters with a meaning of their own
    localparam logic [7:0] CH_BELL = 8'h07;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LO_Z = 8'h7A;
    localparam logic [7:0] CH_UP_Z = 8'h5A;
    localparam logic [7:0] CH_LO_T = 8'h74;
    localparam logic [7:0] CH_UP_T = 8'h54;
    localparam logic [7:0] CH_LO_R = 8'h72;
    localparam logic [7:0] CH_UP_R = 8'h52;
    localparam logic [7:0] CH_LO_A = 8'h61;
    localparam logic [7:0] CH_UP_A = 8'h41;
    localparam logic [7:0] CH_ZERO = 8'h30;

    localparam int ID_DIGITS_STD = 3;
    localparam int ID_DIGITS_EXT = 8;
    localparam logic [7:0] MAX_DLC = 8'd8;

    // Work handed from the front part to the back part
    typedef enum logic [1:0] {
        OP_WRITE,
        OP_OK,
        OP_BELL,
        OP_PARSE
    } op_kind_t;

    typedef struct packed {
        op_kind_t   kind;
        logic [7:0] char_val;  // character to store (write)
        len_t       idx;       // store address (write) or line length (parse)
        logic       ext;       // uppercase command letter (parse)
        logic       rtr;       // remote frame command letter (parse)
    } op_t;

    typedef enum logic [1:0] {
        EV_FRAME = 2'd0,
        EV_OK    = 2'd1,
        EV_BELL  = 2'd2
    } event_t;

    // One result item, last field in the lowest bits
    typedef struct packed {
        logic [63:0] payload;
        logic [3:0]  data_length;
        logic        remote_request;
        logic        extended_id;
        logic [31:0] frame_id;
        event_t      event_res;
    } result_t;

    // Map a character to its digit value, wrapping modulo 256
    function automatic logic [7:0] hex_value(input logic [7:0] c);
        logic [7:0] v;
        if (c >= CH_LO_A) begin
            v = c - CH_LO_A + 8'd10;
        end else if (c >= CH_UP_A) begin
            v = c - CH_UP_A + 8'd10;
        end else begin
            v = c - CH_ZERO;
        end
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/slcan_front.sv =====
// Front part: accepts received characters, tracks the line length and classifies each item.
`default_nettype none

module slcan_front #(
    parameter int LINE_CHARS = 32
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [7:0]       s_tdata,
    input  wire logic             q_ready,
    output logic                  q_push,
    output slcan_pkg::op_t        q_op
);

    localparam int LW = $clog2(LINE_CHARS + 1);

    logic [LW-1:0] len_reg, len_next;
    logic [7:0]    first_reg, first_next;
    logic          accept;
    logic          letter_ok;
    logic          ext;
    logic          rtr;
    slcan_pkg::len_t min_len;

    assign s_tready = q_ready;
    assign accept   = s_tvalid && q_ready;

    // Decode the command letter from the first stored character
    always_comb begin
        letter_ok = (first_reg == slcan_pkg::CH_LO_T) || (first_reg == slcan_pkg::CH_UP_T) ||
                    (first_reg == slcan_pkg::CH_LO_R) || (first_reg == slcan_pkg::CH_UP_R);
        ext       = (first_reg == slcan_pkg::CH_UP_T) || (first_reg == slcan_pkg::CH_UP_R);
        rtr       = (first_reg == slcan_pkg::CH_LO_R) || (first_reg == slcan_pkg::CH_UP_R);
        min_len   = ext ? slcan_pkg::len_t'(slcan_pkg::ID_DIGITS_EXT + 2)
                        : slcan_pkg::len_t'(slcan_pkg::ID_DIGITS_STD + 2);
    end

    // Classify the item and push the resulting work
    always_comb begin
        len_next      = len_reg;
        first_next    = first_reg;
        q_push        = 1'b0;
        q_op          = '0;
        q_op.char_val = s_tdata;
        q_op.idx      = slcan_pkg::len_t'(len_reg);
        q_op.ext      = ext;
        q_op.rtr      = rtr;
        if (accept) begin
            priority if (s_tdata == slcan_pkg::CH_BELL) begin
                len_next  = '0;
                q_push    = 1'b1;
                q_op.kind = slcan_pkg::OP_BELL;
            end else if (s_tdata == slcan_pkg::CH_CR) begin
                len_next = '0;
                priority if (len_reg == '0 || first_reg == slcan_pkg::CH_LO_Z ||
                             first_reg == slcan_pkg::CH_UP_Z) begin
                    q_push    = 1'b1;
                    q_op.kind = slcan_pkg::OP_OK;
                end else if (letter_ok && slcan_pkg::len_t'(len_reg) >= min_len) begin
                    q_push    = 1'b1;
                    q_op.kind = slcan_pkg::OP_PARSE;
                end else begin
                    q_push = 1'b0;
                end
            end else if (len_reg < LW'(LINE_CHARS)) begin
                q_push    = 1'b1;
                q_op.kind = slcan_pkg::OP_WRITE;
                len_next  = len_reg + LW'(1);
                if (len_reg == '0) begin
                    first_next = s_tdata;
                end
            end else begin
                // drop the whole line on overflow
                len_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= '0;
        end else begin
            len_reg <= len_next;
        end
        first_reg <= first_next;
    end

endmodule

`default_nettype wire

// ===== hdl/slcan_queue.sv =====
// Two-entry queue of classified work between the front and back parts.
`default_nettype none

module slcan_queue (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  wire slcan_pkg::op_t push_op,
    output logic                in_ready,
    output logic                out_valid,
    output slcan_pkg::op_t      out_op,
    input  wire logic           pop
);

    slcan_pkg::op_t entry_reg [2];
    logic           wr_ptr_reg, rd_ptr_reg;
    logic [1:0]     count_reg;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_op    = entry_reg[rd_ptr_reg];

    // Store on push
    always_ff @(posedge aclk) begin
        if (push && in_ready) begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push && in_ready) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop && out_valid) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push && in_ready} - {1'b0, pop && out_valid};
        end
    end

endmodule

`default_nettype wire

// ===== hdl/slcan_back.sv =====
// Back part: owns the line store, walks a stored line to build a frame, drives the result item.
`default_nettype none

module slcan_back #(
    parameter int LINE_CHARS = 32
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           q_valid,
    input  wire slcan_pkg::op_t q_op,
    output logic                q_pop,
    output logic                m_tvalid,
    input  wire logic           m_tready,
    output slcan_pkg::result_t  m_res
);

    localparam int AW = $clog2(LINE_CHARS);

    typedef enum logic [1:0] {
        B_IDLE  = 2'b01,
        B_PARSE = 2'b10
    } bstate_t;

    logic [7:0] mem [LINE_CHARS];

    bstate_t            state_reg, state_next;
    logic [AW-1:0]      addr_reg, addr_next;
    logic [AW-1:0]      pos_reg, pos_next;
    logic               rd_ok_reg, rd_ok_next;
    logic [7:0]         rdata_reg;
    slcan_pkg::len_t    len_reg, len_next;
    logic               ext_reg, ext_next;
    logic               rtr_reg, rtr_next;
    logic [31:0]        id_reg, id_next;
    logic [3:0]         dlc_reg, dlc_next;
    logic [3:0]         hi_reg, hi_next;
    logic [63:0]        data_reg, data_next;
    logic               m_valid_reg, m_valid_next;
    slcan_pkg::result_t res_reg, res_next;

    logic          mem_we;
    logic          out_free;
    logic [AW-1:0] dg;
    logic [7:0]    hv;
    logic [AW-1:0] off;
    logic [2:0]    k;
    logic [7:0]    byte_val;
    logic [7:0]    need;

    assign m_tvalid = m_valid_reg;
    assign m_res    = res_reg;

    // Line store: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[q_op.idx[AW-1:0]] <= q_op.char_val;
        end
        rdata_reg <= mem[addr_reg];
    end

    // Per-character decode of the walked line
    always_comb begin
        out_free = !m_valid_reg || m_tready;
        dg       = ext_reg ? AW'(slcan_pkg::ID_DIGITS_EXT) : AW'(slcan_pkg::ID_DIGITS_STD);
        hv       = slcan_pkg::hex_value(rdata_reg);
        off      = pos_reg - dg - AW'(2);
        k        = off[3:1];
        byte_val = {hi_reg, 4'h0} + hv;
        need     = 8'(dg) + 8'd2 + {hv[6:0], 1'b0};
    end

    // Sequence the work items and the line walk
    always_comb begin
        state_next   = state_reg;
        addr_next    = addr_reg;
        pos_next     = pos_reg;
        rd_ok_next   = rd_ok_reg;
        len_next     = len_reg;
        ext_next     = ext_reg;
        rtr_next     = rtr_reg;
        id_next      = id_reg;
        dlc_next     = dlc_reg;
        hi_next      = hi_reg;
        data_next    = data_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg && !m_tready;
        q_pop        = 1'b0;
        mem_we       = 1'b0;

        unique case (state_reg)
            B_IDLE: begin
                if (q_valid) begin
                    unique case (q_op.kind)
                        slcan_pkg::OP_WRITE: begin
                            mem_we = 1'b1;
                            q_pop  = 1'b1;
                        end
                        slcan_pkg::OP_OK, slcan_pkg::OP_BELL: begin
                            if (out_free) begin
                                q_pop        = 1'b1;
                                m_valid_next = 1'b1;
                                res_next     = '0;
                                res_next.event_res = (q_op.kind == slcan_pkg::OP_OK) ?
                                                     slcan_pkg::EV_OK : slcan_pkg::EV_BELL;
                            end
                        end
                        slcan_pkg::OP_PARSE: begin
                            if (!m_valid_reg) begin
                                q_pop      = 1'b1;
                                len_next   = q_op.idx;
                                ext_next   = q_op.ext;
                                rtr_next   = q_op.rtr;
                                addr_next  = AW'(1);
                                rd_ok_next = 1'b0;
                                id_next    = '0;
                                data_next  = '0;
                                state_next = B_PARSE;
                            end
                        end
                    endcase
                end
            end
            B_PARSE: begin
                // issue the next read while the previous character is decoded
                addr_next  = addr_reg + AW'(1);
                pos_next   = addr_reg;
                rd_ok_next = 1'b1;
                if (rd_ok_reg) begin
                    priority if (pos_reg <= dg) begin
                        id_next = {id_reg[27:0], 4'h0} + 32'(hv);
                    end else if (pos_reg == dg + AW'(1)) begin
                        priority if (hv > slcan_pkg::MAX_DLC) begin
                            state_next = B_IDLE;
                        end else if (rtr_reg || hv == 8'd0) begin
                            m_valid_next            = 1'b1;
                            res_next.event_res      = slcan_pkg::EV_FRAME;
                            res_next.frame_id       = id_reg;
                            res_next.extended_id    = ext_reg;
                            res_next.remote_request = rtr_reg;
                            res_next.data_length    = hv[3:0];
                            res_next.payload        = '0;
                            state_next              = B_IDLE;
                        end else if (8'(len_reg) < need) begin
                            state_next = B_IDLE;
                        end else begin
                            dlc_next = hv[3:0];
                        end
                    end else begin
                        if (!off[0]) begin
                            hi_next = hv[3:0];
                        end else begin
                            data_next[{3'd7 - k, 3'b000} +: 8] = byte_val;
                            if ({1'b0, k} == dlc_reg - 4'd1) begin
                                m_valid_next            = 1'b1;
                                res_next.event_res      = slcan_pkg::EV_FRAME;
                                res_next.frame_id       = id_reg;
                                res_next.extended_id    = ext_reg;
                                res_next.remote_request = rtr_reg;
                                res_next.data_length    = dlc_reg;
                                res_next.payload        = data_next;
                                state_next              = B_IDLE;
                            end
                        end
                    end
                end
            end
            default: begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_IDLE;
            m_valid_reg <= 1'b0;
            rd_ok_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            rd_ok_reg   <= rd_ok_next;
        end
        addr_reg <= addr_next;
        pos_reg  <= pos_next;
        len_reg  <= len_next;
        ext_reg  <= ext_next;
        rtr_reg  <= rtr_next;
        id_reg   <= id_next;
        dlc_reg  <= dlc_next;
        hi_reg   <= hi_next;
        data_reg <= data_next;
        res_reg  <= res_next;
    end

endmodule

`default_nettype wire

// ===== hdl/slcan_line_to_can_frame.sv =====
// Top level: serial character stream in, decoded frame and status items out.
//
//  channel   dir  tdata fields (lowest bit up)                       tuser           tlast
//  s_ (rx)   in   rx_byte[7:0]                                       -               -
//  m_ (res)  out  frame_id[31:0] extended_id[32] remote_request[33]  event_res[1:0]  -
//                 data_length[37:34] payload[101:38], zero fill[103:102]
//
// A character enters while the queue has room; the back part stores it from the queue.
// For a carriage return that parses, the back part walks the stored line through the
// single read port of the line store, at most 25 characters.
// Reset (aresetn low, synchronous) empties the queue and the line and clears result valid.
// A stalled result blocks only further results; characters keep entering until the
// two-entry queue fills.
`default_nettype none
`include "assert_macros.svh"

module slcan_line_to_can_frame #(
    parameter int LINE_CHARS = 32
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [7:0]   s_tdata,   // rx_byte[7:0]
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [103:0]      m_tdata,   // frame_id, extended_id, remote_request,
                                         // data_length, payload, zero fill
    output logic [1:0]        m_tuser    // event_res
);

    logic               q_ready;
    logic               q_push;
    slcan_pkg::op_t     q_in_op;
    logic               q_valid;
    slcan_pkg::op_t     q_out_op;
    logic               q_pop;
    slcan_pkg::result_t m_res;
    logic               res_status;
    logic               res_frame;
    logic               status_empty;

    slcan_front #(
        .LINE_CHARS (LINE_CHARS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_ready  (q_ready),
        .q_push   (q_push),
        .q_op     (q_in_op)
    );

    slcan_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_op   (q_in_op),
        .in_ready  (q_ready),
        .out_valid (q_valid),
        .out_op    (q_out_op),
        .pop       (q_pop)
    );

    slcan_back #(
        .LINE_CHARS (LINE_CHARS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_op     (q_out_op),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_res    (m_res)
    );

    // Pack the frame fields into tdata, the event kind into tuser
    assign m_tdata = {2'b00, m_res.payload, m_res.data_length, m_res.remote_request,
                      m_res.extended_id, m_res.frame_id};
    assign m_tuser = m_res.event_res;

    // Classify the offered result for the checks below
    assign res_frame    = m_tvalid && (m_res.event_res == slcan_pkg::EV_FRAME);
    assign res_status   = m_tvalid && (m_res.event_res != slcan_pkg::EV_FRAME);
    assign status_empty = (m_res.frame_id == 32'd0) && (m_res.payload == 64'd0) &&
                          (m_res.data_length == 4'd0);

    // Status items carry no frame content
    `SLC_ASSERT_RST(a_status_clean, aclk, aresetn, res_status |-> status_empty, "status item with frame content")
    // Decoded frames never exceed eight data bytes
    `SLC_ASSERT_RST(a_dlc_range, aclk, aresetn, res_frame |-> (m_res.data_length <= 4'd8), "frame length above eight")
    // Remote frames carry an empty payload
    `SLC_ASSERT_RST(a_remote_empty, aclk, aresetn, (res_frame && m_res.remote_request) |-> (m_res.payload == 64'd0), "remote frame with payload")
    // No result is offered right after reset
    `SLC_ASSERT_ALWAYS(a_reset_quiet, aclk, (!aresetn) |=> (!m_tvalid), "result valid after reset")

endmodule

`default_nettype wire
